>>> rtl/fdtsbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdtsbt_pkg
// token codes, item kinds and defaults for the structure block tokenizer
// ----------------------------------------------------------------------------
package fdtsbt_pkg;

  // token codes after the byte swap
  localparam logic [31:0] TOK_BEGIN    = 32'd1;
  localparam logic [31:0] TOK_END_NODE = 32'd2;
  localparam logic [31:0] TOK_PROP     = 32'd3;
  localparam logic [31:0] TOK_NOP      = 32'd4;
  localparam logic [31:0] TOK_END      = 32'd9;

  // classification of each word
  typedef enum logic [3:0] {
    K_BEGIN = 4'd0,
    K_NAME  = 4'd1,
    K_ENDN  = 4'd2,
    K_PROP  = 4'd3,
    K_LEN   = 4'd4,
    K_OFF   = 4'd5,
    K_DATA  = 4'd6,
    K_NOP   = 4'd7,
    K_END   = 4'd8,
    K_BAD   = 4'd9,
    K_IGN   = 4'd10
  } kind_t;

  localparam int FDT_MAX_DEPTH_DEF = 64;

  // word as read from memory into big-endian value
  function automatic logic [31:0] swap32(input logic [31:0] w);
    swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic has_zero_byte(input logic [31:0] w);
    has_zero_byte = (w[7:0] == 8'd0) || (w[15:8] == 8'd0) ||
                    (w[23:16] == 8'd0) || (w[31:24] == 8'd0);
  endfunction

endpackage
`default_nettype wire

>>> rtl/fdt_struct_block_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdt_struct_block_tokenizer
// classifies the words of a devicetree structure block, one word per item
// ----------------------------------------------------------------------------
// Takes the structure block as 32-bit words in memory byte order (first byte
// in bits 7..0) and returns one result item per input item, giving the kind
// of each word, the byte-swapped value for tokens, lengths and name offsets
// (the raw word for names, property data and ignored words), the node depth
// after the word, a last-of-field mark and a depth fault flag. A start flag
// on an item clears all parse state before that word is read as a token. An
// unknown token halts parsing, and after the end token every word is ignored,
// until the next start. The block takes one item per cycle when the result
// channel does not stall: an input register feeds a single pass of
// classification logic into the result register, and the phase/depth state
// updates with each word that moves into the result register.
// ----------------------------------------------------------------------------
module fdt_struct_block_tokenizer
  import fdtsbt_pkg::*;
#(
  parameter int MAX_DEPTH = FDT_MAX_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] word
  input  wire logic        in_tuser,   // [0] start_req
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] fixed_word, [38:32] depth, [39] zero
  output logic             out_tlast,  // closes_field
  output logic [4:0]       out_tuser   // [3:0] kind, [4] depth_fault
);

  // depth counter holds 0..MAX_DEPTH
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int EW = (DW > 7) ? DW : 7;
  localparam logic [DW-1:0] MAX_D = DW'(MAX_DEPTH);

  // parse phases
  localparam logic [2:0] PH_TOKEN      = 3'd0;
  localparam logic [2:0] PH_NAME       = 3'd1;
  localparam logic [2:0] PH_LEN        = 3'd2;
  localparam logic [2:0] PH_OFF_DATA   = 3'd3;
  localparam logic [2:0] PH_OFF_NODATA = 3'd4;
  localparam logic [2:0] PH_DATA       = 3'd5;
  localparam logic [2:0] PH_DONE       = 3'd6;

  // input register
  logic        s1_valid_r;
  logic [31:0] s1_word_r;
  logic        s1_start_r;

  // parse state
  logic [2:0]    phase_r, phase_nxt;
  logic [29:0]   dwl_r, dwl_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          halted_r, halted_nxt;

  // result register
  logic          out_valid_r;
  logic [31:0]   fixed_r, fixed_nxt;
  logic [6:0]    odepth_r;
  logic          closes_r, closes_nxt;
  logic          fault_r, fault_nxt;
  kind_t         kind_r, kind_nxt;

  logic          out_free;
  logic          s1_move;

  // state seen by this word, after an optional start
  logic [2:0]    ph_cur;
  logic [29:0]   dwl_cur;
  logic [DW-1:0] depth_cur;
  logic          halted_cur;
  logic [31:0]   sw;
  logic [31:0]   sw_m1;
  logic [EW-1:0] depth_ext;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_word_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  always_comb begin
    ph_cur     = s1_start_r ? PH_TOKEN : phase_r;
    dwl_cur    = s1_start_r ? 30'd0 : dwl_r;
    depth_cur  = s1_start_r ? '0 : depth_r;
    halted_cur = s1_start_r ? 1'b0 : halted_r;
    sw         = swap32(s1_word_r);
    sw_m1      = sw - 32'd1;

    phase_nxt  = ph_cur;
    dwl_nxt    = dwl_cur;
    depth_nxt  = depth_cur;
    halted_nxt = halted_cur;
    kind_nxt   = K_IGN;
    fixed_nxt  = s1_word_r;
    closes_nxt = 1'b0;
    fault_nxt  = 1'b0;

    if (halted_cur || ph_cur == PH_DONE) begin
      kind_nxt = K_IGN;
    end else begin
      case (ph_cur)
        PH_TOKEN: begin
          fixed_nxt = sw;
          case (sw)
            TOK_BEGIN: begin
              kind_nxt = K_BEGIN;
              if (depth_cur >= MAX_D) begin
                fault_nxt = 1'b1;
              end else begin
                depth_nxt = depth_cur + DW'(1);
              end
              phase_nxt = PH_NAME;
            end
            TOK_END_NODE: begin
              kind_nxt = K_ENDN;
              if (depth_cur == '0) begin
                fault_nxt = 1'b1;
              end else begin
                depth_nxt = depth_cur - DW'(1);
              end
            end
            TOK_PROP: begin
              kind_nxt  = K_PROP;
              phase_nxt = PH_LEN;
            end
            TOK_NOP: begin
              kind_nxt = K_NOP;
            end
            TOK_END: begin
              kind_nxt  = K_END;
              phase_nxt = PH_DONE;
            end
            default: begin
              // unknown token stops parsing until the next start
              kind_nxt   = K_BAD;
              halted_nxt = 1'b1;
            end
          endcase
        end
        PH_NAME: begin
          kind_nxt = K_NAME;
          if (has_zero_byte(s1_word_r)) begin
            closes_nxt = 1'b1;
            phase_nxt  = PH_TOKEN;
          end
        end
        PH_LEN: begin
          kind_nxt  = K_LEN;
          fixed_nxt = sw;
          if (sw == 32'd0) begin
            dwl_nxt   = 30'd0;
            phase_nxt = PH_OFF_NODATA;
          end else begin
            // words after the first: ceil(len/4) - 1
            dwl_nxt   = sw_m1[31:2];
            phase_nxt = PH_OFF_DATA;
          end
        end
        PH_OFF_DATA, PH_OFF_NODATA: begin
          kind_nxt  = K_OFF;
          fixed_nxt = sw;
          phase_nxt = (ph_cur == PH_OFF_DATA) ? PH_DATA : PH_TOKEN;
        end
        PH_DATA: begin
          kind_nxt = K_DATA;
          if (dwl_cur == 30'd0) begin
            closes_nxt = 1'b1;
            phase_nxt  = PH_TOKEN;
          end else begin
            dwl_nxt = dwl_cur - 30'd1;
          end
        end
        default: begin
          kind_nxt = K_IGN;
        end
      endcase
    end

    depth_ext = EW'(depth_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOKEN;
      dwl_r       <= 30'd0;
      depth_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        phase_r  <= phase_nxt;
        dwl_r    <= dwl_nxt;
        depth_r  <= depth_nxt;
        halted_r <= halted_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      kind_r   <= kind_nxt;
      fixed_r  <= fixed_nxt;
      odepth_r <= depth_ext[6:0];
      closes_r <= closes_nxt;
      fault_r  <= fault_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, odepth_r, fixed_r};
  assign out_tlast  = closes_r;
  assign out_tuser  = {fault_r, kind_r};

`ifndef NO_ASSERTIONS
  // depth counter never leaves its range
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= MAX_D)
    else $error("nesting depth above maximum");

  // a bad token on the output means parsing is halted
  a_bad_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == K_BAD) |-> halted_r)
    else $error("bad token without halt");

  // last-of-field only on name or data words
  a_close_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && closes_r) |-> (kind_r == K_NAME || kind_r == K_DATA))
    else $error("field close on wrong kind");

  // depth fault only on node tokens
  a_fault_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fault_r) |-> (kind_r == K_BEGIN || kind_r == K_ENDN))
    else $error("depth fault on wrong kind");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the devicetree structure block tokenizer
// ----------------------------------------------------------------------------
// Streams structure block words into the tokenizer and checks every result
// item against a cycle-free predictor of the parse: kind, fixed word, depth,
// last-of-field mark and depth fault. A directed opener covers every token,
// names, zero and short property lengths, depth underflow, bad tokens and
// the end token; huge lengths are cut short by a restart; a deep nesting run
// pushes the nesting past its ceiling and closes past zero; then well-formed
// random blocks with random content, mixed with noise, broken sequences and
// restarts, run under three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import fdtsbt_pkg::*;

  localparam int DEPTH_LIMIT = FDT_MAX_DEPTH_DEF;

  // parse phases of the predictor
  typedef enum logic [2:0] {
    TOKEN_WAIT,
    NAME_WORDS,
    LEN_WORD,
    OFF_THEN_DATA,
    OFF_ONLY,
    DATA_WORDS,
    BLOCK_DONE
  } parse_phase_t;

  // one classified word as the block reports it
  typedef struct packed {
    kind_t       kind;
    logic [31:0] fixed;
    logic [6:0]  depth;
    logic        closes;
    logic        fault;
  } word_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [4:0]  out_tuser;

  // stall rates in percent, changed between the phases of the run
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // results still owed by the block, oldest first
  word_result_t owed_results[$];
  int           fail_count   = 0;
  int           parsed_words = 0;   // words that were not merely ignored

  // predictor's copy of the parse state
  parse_phase_t parse_phase;
  logic [29:0]  data_left;
  int           nest;
  logic         parse_halted;

  fdt_struct_block_tokenizer #(
    .MAX_DEPTH (DEPTH_LIMIT)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // memory byte order <-> big-endian value; the swap is its own inverse
  function automatic logic [31:0] byte_reverse(input logic [31:0] w);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) r[8*b +: 8] = w[8*(3-b) +: 8];
    return r;
  endfunction

  function automatic logic holds_nul(input logic [31:0] w);
    logic z;
    z = 1'b0;
    for (int b = 0; b < 4; b++) if (w[8*b +: 8] == 8'h00) z = 1'b1;
    return z;
  endfunction

  function automatic void clear_parse_state();
    parse_phase  = TOKEN_WAIT;
    data_left    = '0;
    nest         = 0;
    parse_halted = 1'b0;
  endfunction

  // classifies one word and advances the parse state
  function automatic word_result_t classify_word(input logic [31:0] raw,
                                                 input logic start);
    word_result_t res;
    logic [31:0]  val;
    val        = byte_reverse(raw);
    res.kind   = K_IGN;
    res.fixed  = raw;
    res.closes = 1'b0;
    res.fault  = 1'b0;
    if (start) clear_parse_state();
    if (parse_halted || parse_phase == BLOCK_DONE) begin
      res.kind = K_IGN;
    end else begin
      case (parse_phase)
        TOKEN_WAIT: begin
          res.fixed = val;
          case (val)
            TOK_BEGIN: begin
              res.kind = K_BEGIN;
              // at the ceiling the depth holds but the name still follows
              if (nest >= DEPTH_LIMIT) res.fault = 1'b1;
              else nest++;
              parse_phase = NAME_WORDS;
            end
            TOK_END_NODE: begin
              res.kind = K_ENDN;
              if (nest == 0) res.fault = 1'b1;
              else nest--;
            end
            TOK_PROP: begin
              res.kind    = K_PROP;
              parse_phase = LEN_WORD;
            end
            TOK_NOP: res.kind = K_NOP;
            TOK_END: begin
              res.kind    = K_END;
              parse_phase = BLOCK_DONE;
            end
            default: begin
              res.kind     = K_BAD;
              parse_halted = 1'b1;
            end
          endcase
        end
        NAME_WORDS: begin
          res.kind = K_NAME;
          if (holds_nul(raw)) begin
            res.closes  = 1'b1;
            parse_phase = TOKEN_WAIT;
          end
        end
        LEN_WORD: begin
          res.kind  = K_LEN;
          res.fixed = val;
          if (val == 32'd0) begin
            data_left   = '0;
            parse_phase = OFF_ONLY;
          end else begin
            // words still to come after the first: ceil(len/4) - 1
            data_left   = 30'((val - 32'd1) >> 2);
            parse_phase = OFF_THEN_DATA;
          end
        end
        OFF_THEN_DATA, OFF_ONLY: begin
          res.kind    = K_OFF;
          res.fixed   = val;
          parse_phase = (parse_phase == OFF_THEN_DATA) ? DATA_WORDS : TOKEN_WAIT;
        end
        DATA_WORDS: begin
          res.kind = K_DATA;
          if (data_left == '0) begin
            res.closes  = 1'b1;
            parse_phase = TOKEN_WAIT;
          end else begin
            data_left--;
          end
        end
        default: res.kind = K_IGN;
      endcase
    end
    res.depth = nest[6:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driving side
  // ---------------------------------------------------------------------------

  // offers one item, waits for the handshake and books its expected result;
  // tvalid stays high into the next item unless an idle stretch is drawn
  task automatic send_word(input logic [31:0] w, input logic start);
    word_result_t res;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = classify_word(w, start);
    owed_results.push_back(res);
    if (res.kind != K_IGN) parsed_words++;
  endtask

  function automatic logic [31:0] word_without_nul();
    logic [31:0] w;
    for (int b = 0; b < 4; b++) w[8*b +: 8] = 8'($urandom_range(1, 255));
    return w;
  endfunction

  // a node name: some full words, then one with a nul in a random byte
  task automatic send_name();
    int unsigned n;
    logic [31:0] w;
    n = $urandom_range(0, 3);
    repeat (n) send_word(word_without_nul(), 1'b0);
    w = $urandom;
    w[8*$urandom_range(0, 3) +: 8] = 8'h00;
    send_word(w, 1'b0);
  endtask

  task automatic open_node(input logic start);
    send_word(byte_reverse(TOK_BEGIN), start);
    send_name();
  endtask

  // property token, length, name offset and data; a huge length is cut short
  // by a restart, since its data would never end
  task automatic send_prop(input logic [31:0] len);
    longint nwords;
    send_word(byte_reverse(TOK_PROP), 1'b0);
    send_word(byte_reverse(len), 1'b0);
    send_word($urandom, 1'b0);
    nwords = (longint'(len) + 3) / 4;
    if (nwords > 64) begin
      repeat (3) send_word($urandom, 1'b0);
      open_node(1'b1);
    end else begin
      repeat (nwords) send_word($urandom, 1'b0);
    end
  endtask

  function automatic logic [31:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15)      return 32'd0;
    else if (r < 70) return 32'($urandom_range(1, 16));
    else if (r < 95) return 32'($urandom_range(17, 64));
    else             return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // receiver stalls at the rate in force
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    word_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = kind_t'(out_tuser[3:0]);
      got.fault  = out_tuser[4];
      got.fixed  = out_tdata[31:0];
      got.depth  = out_tdata[38:32];
      got.closes = out_tlast;
      if (owed_results.size() == 0) begin
        note_failure($sformatf("unexpected result: kind %0d word %h depth %0d",
                               got.kind, got.fixed, got.depth));
      end else begin
        want = owed_results.pop_front();
        if (got.kind !== want.kind || got.fixed !== want.fixed ||
            got.depth !== want.depth || got.closes !== want.closes ||
            got.fault !== want.fault || out_tdata[39] !== 1'b0) begin
          note_failure($sformatf(
            "mismatch: kind %0d/%0d word %h/%h depth %0d/%0d last %b/%b fault %b/%b pad %b (exp/act)",
            want.kind, got.kind, want.fixed, got.fixed, want.depth, got.depth,
            want.closes, got.closes, want.fault, got.fault, out_tdata[39]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every token kind, name endings, zero and short lengths, underflow,
  // a bad token halting the parse and the end token
  task automatic test_directed();
    send_word(byte_reverse(TOK_BEGIN), 1'b1);
    send_word(32'h0043_4241, 1'b0);            // "ABC" with nul in the top byte
    send_word(byte_reverse(TOK_BEGIN), 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);            // name runs on
    send_word(32'h0000_0000, 1'b0);
    send_prop(32'd0);                          // no data, no last mark
    send_prop(32'd1);
    send_prop(32'd5);
    send_word(byte_reverse(TOK_NOP), 1'b0);
    repeat (3) send_word(byte_reverse(TOK_END_NODE), 1'b0);  // last one underflows
    send_word(32'h1234_5678, 1'b0);            // unknown token
    send_word(byte_reverse(TOK_BEGIN), 1'b0);  // ignored while halted
    send_word(byte_reverse(TOK_END), 1'b1);
    send_word(32'h0000_0000, 1'b0);            // ignored after the end
  endtask

  // the largest length a property can carry, cut off by a restart
  task automatic test_long_property();
    open_node(1'b1);
    send_prop(32'hFFFF_FFFF);
    send_prop(32'h8000_0001);
  endtask

  // nest past the ceiling, then close past zero
  task automatic test_deep_nesting();
    open_node(1'b1);
    repeat (DEPTH_LIMIT + 2) open_node(1'b0);
    send_prop(32'd4);
    repeat (DEPTH_LIMIT + 3) send_word(byte_reverse(TOK_END_NODE), 1'b0);
    send_word(byte_reverse(TOK_END), 1'b0);
  endtask

  // mostly well-formed blocks with random content, with noise and broken
  // sequences mixed in; ignored words do not count toward the total
  task automatic test_random_blocks(input int n);
    int          goal;
    int unsigned r;
    goal = parsed_words + n;
    open_node(1'b1);
    while (parsed_words < goal) begin
      r = $urandom_range(99);
      // keep the nesting shallow so that ends and begins both matter
      if (r < 28 && nest < 10) begin
        open_node(1'b0);
      end else if (r < 50) begin
        send_word(byte_reverse(TOK_END_NODE), 1'b0);
      end else if (r < 82) begin
        send_prop(pick_length());
      end else if (r < 87) begin
        send_word(byte_reverse(TOK_NOP), 1'b0);
      end else if (r < 91) begin
        // noise: almost surely a bad token, then the halt and a restart
        send_word($urandom, $urandom_range(1));
        repeat ($urandom_range(0, 2)) send_word($urandom, 1'b0);
        open_node(1'b1);
      end else if (r < 94) begin
        send_word(byte_reverse(TOK_END), 1'b0);
        repeat ($urandom_range(0, 2)) send_word($urandom, 1'b0);
        open_node(1'b1);
      end else if (r < 97) begin
        // broken sequence: a start in the middle of a name or a property
        if ($urandom_range(1)) begin
          send_word(byte_reverse(TOK_BEGIN), 1'b0);
          send_word(word_without_nul(), 1'b0);
        end else begin
          send_word(byte_reverse(TOK_PROP), 1'b0);
          send_word(byte_reverse(32'd12), 1'b0);
          send_word($urandom, 1'b0);
          send_word($urandom, 1'b0);
        end
        open_node(1'b1);
      end else begin
        open_node(1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_parse_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver stalls heavily
    tx_idle_pct = 35;
    rx_idle_pct = 78;
    test_directed();
    test_long_property();
    test_deep_nesting();
    test_random_blocks(220);

    // the other way round
    tx_idle_pct = 78;
    rx_idle_pct = 35;
    test_random_blocks(220);

    // full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_blocks(230);
    in_tvalid <= 1'b0;

    // drain, then give the pipeline time to show any stray result
    for (int c = 0; c < 5000 && owed_results.size() > 0; c++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (owed_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", owed_results.size()));

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
